FILE: rtl/cffa_pkg.sv
// Shared types and constants for the contiguous first-fit allocator.
// No dependencies; imported by the top level.
package cffa_pkg;

   localparam int NUM_BLOCKS_DEF      = 128;
   localparam int UNITS_PER_BLOCK_DEF = 10;
   localparam int NUM_FILES_DEF       = 16;

   // Fixed field widths of the request and response channels
   localparam int ID_W    = 4;
   localparam int SIZE_W  = 12;
   localparam int START_W = 7;
   localparam int COUNT_W = 8;

   typedef enum logic {
      OP_CREATE = 1'b0,
      OP_DELETE = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_DUPLICATE = 2'd1,
      ST_NO_ROOM   = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_LOAD,
      S_SCAN,
      S_MARK,
      S_RESULT
   } state_type;

endpackage

FILE: rtl/cffa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module cffa_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 128,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/contiguous_first_fit_allocator.sv
// Top level of the contiguous first-fit block allocator: sequencer, block map scan and file table.
// Depends on cffa_pkg and cffa_ram.
//
//   channel | ports                                          | direction
//   --------+------------------------------------------------+----------
//   request | req_valid req_stall req_opcode req_file_id      | in
//           | req_size_units                                 |
//   response| rsp_valid rsp_stall rsp_status rsp_start_block | out
//           | rsp_block_count                                |
//
// After reset the block map RAM is swept to zero, one block at a time, with req_stall high.
// A create scans the map one block per cycle through the map RAM read port, marks each block
// of the first run that fits as used, then posts the result.
// A delete reads its file table entry, frees each block of the run, then posts the result.
// Duplicate and missing-id requests go straight to the result step.
// req_stall is high while a transaction is in work; a result waits in the response register
// while rsp_stall is high and the next request is still taken.
module contiguous_first_fit_allocator #(
   parameter int NUM_BLOCKS      = cffa_pkg::NUM_BLOCKS_DEF,
   parameter int UNITS_PER_BLOCK = cffa_pkg::UNITS_PER_BLOCK_DEF,
   parameter int NUM_FILES       = cffa_pkg::NUM_FILES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_opcode,
   input  logic [cffa_pkg::ID_W-1:0]    req_file_id,
   input  logic [cffa_pkg::SIZE_W-1:0]  req_size_units,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic [cffa_pkg::START_W-1:0] rsp_start_block,
   output logic [cffa_pkg::COUNT_W-1:0] rsp_block_count
);
   import cffa_pkg::*;

   localparam int ABW  = $clog2(NUM_BLOCKS);
   localparam int CW   = $clog2(NUM_BLOCKS + 1);
   localparam int FIW  = $clog2(NUM_FILES);
   localparam int RUW  = $clog2(NUM_BLOCKS * UNITS_PER_BLOCK + 1);
   localparam int CMPW = (RUW > SIZE_W) ? RUW : SIZE_W;
   localparam int EW   = ABW + CW;

   state_type            state_ff, state_in;
   opcode_type           op_ff, op_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [SIZE_W-1:0]    units_ff, units_in;
   logic [NUM_FILES-1:0] entry_valid_ff, entry_valid_in;

   logic [ABW:0]         addr_ff, addr_in;
   logic                 pend_ff, pend_in;
   logic [ABW-1:0]       pend_idx_ff, pend_idx_in;
   logic [CW-1:0]        run_ff, run_in;
   logic [RUW-1:0]       run_units_ff, run_units_in;
   logic [ABW-1:0]       run_start_ff, run_start_in;

   logic [ABW-1:0]       mark_addr_ff, mark_addr_in;
   logic [CW-1:0]        mark_left_ff, mark_left_in;
   logic                 mark_val_ff, mark_val_in;

   status_type           res_status_ff, res_status_in;
   logic [ABW-1:0]       res_start_ff, res_start_in;
   logic [CW-1:0]        res_count_ff, res_count_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [START_W-1:0]   rsp_start_ff, rsp_start_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic [ID_W+FIW-1:0]     id_wide;
   logic [FIW-1:0]          id_idx;
   logic                    id_ok;
   logic [START_W+ABW-1:0]  start_wide;
   logic [COUNT_W+CW-1:0]   count_wide;

   logic                 map_wr_en, map_wr_data, map_rd_data;
   logic [ABW-1:0]       map_wr_addr;
   logic                 entry_wr_en;
   logic [EW-1:0]        entry_rd_data;

   logic [CW-1:0]        run_next;
   logic [RUW-1:0]       units_next;
   logic [ABW-1:0]       start_next;
   logic                 fit;
   logic                 scan_last;
   logic                 rsp_free;

   assign id_wide    = {{FIW{1'b0}}, id_ff};
   assign id_idx     = id_wide[FIW-1:0];
   assign id_ok      = id_wide < (ID_W + FIW)'(NUM_FILES);
   assign start_wide = {{START_W{1'b0}}, res_start_ff};
   assign count_wide = {{COUNT_W{1'b0}}, res_count_ff};

   // Shared scan unit: two adds and a fit compare per map bit
   assign run_next   = run_ff + CW'(1);
   assign units_next = run_units_ff + RUW'(UNITS_PER_BLOCK);
   assign start_next = (run_ff == '0) ? pend_idx_ff : run_start_ff;
   assign fit        = pend_ff && !map_rd_data && (CMPW'(units_next) >= CMPW'(units_ff));
   assign scan_last  = pend_ff && (pend_idx_ff == ABW'(NUM_BLOCKS - 1));
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   cffa_ram #(
      .WIDTH (1),
      .DEPTH (NUM_BLOCKS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_addr (addr_ff[ABW-1:0]),
      .rd_data (map_rd_data)
   );

   cffa_ram #(
      .WIDTH (EW),
      .DEPTH (NUM_FILES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (entry_wr_en),
      .wr_addr (id_idx),
      .wr_data ({start_next, run_next}),
      .rd_addr (id_idx),
      .rd_data (entry_rd_data)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (mark_addr_ff == ABW'(NUM_BLOCKS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            priority if (!id_ok)                   state_in = S_RESULT;
            else if (op_ff == OP_CREATE) begin
               if (entry_valid_ff[id_idx])         state_in = S_RESULT;
               else                                state_in = S_SCAN;
            end
            else if (entry_valid_ff[id_idx])       state_in = S_LOAD;
            else                                   state_in = S_RESULT;
         end
         S_LOAD: begin
            state_in = S_MARK;
         end
         S_SCAN: begin
            priority if (fit)   state_in = S_MARK;
            else if (scan_last) state_in = S_RESULT;
            else                state_in = S_SCAN;
         end
         S_MARK: begin
            if (mark_left_ff == CW'(1)) state_in = S_RESULT;
         end
         S_RESULT: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs and RAM controls
   always_comb begin
      req_stall   = (state_ff != S_IDLE);
      map_wr_en   = 1'b0;
      map_wr_addr = mark_addr_ff;
      map_wr_data = 1'b0;
      entry_wr_en = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            map_wr_en = 1'b1;
         end
         S_MARK: begin
            map_wr_en   = 1'b1;
            map_wr_data = mark_val_ff;
         end
         S_SCAN: begin
            entry_wr_en = fit;
         end
         default: begin
            map_wr_en = 1'b0;
         end
      endcase
   end

   // Datapath
   always_comb begin
      op_in          = op_ff;
      id_in          = id_ff;
      units_in       = units_ff;
      entry_valid_in = entry_valid_ff;
      addr_in        = addr_ff;
      pend_in        = pend_ff;
      pend_idx_in    = pend_idx_ff;
      run_in         = run_ff;
      run_units_in   = run_units_ff;
      run_start_in   = run_start_ff;
      mark_addr_in   = mark_addr_ff;
      mark_left_in   = mark_left_ff;
      mark_val_in    = mark_val_ff;
      res_status_in  = res_status_ff;
      res_start_in   = res_start_ff;
      res_count_in   = res_count_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_start_in   = rsp_start_ff;
      rsp_count_in   = rsp_count_ff;

      unique case (state_ff)
         S_CLEAR: begin
            mark_addr_in = mark_addr_ff + ABW'(1);
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in    = opcode_type'(req_opcode);
               id_in    = req_file_id;
               units_in = req_size_units;
            end
         end
         S_DISPATCH: begin
            addr_in      = '0;
            pend_in      = 1'b0;
            run_in       = '0;
            run_units_in = '0;
            res_start_in = '0;
            res_count_in = '0;
            priority if (!id_ok)               res_status_in = ST_NOT_FOUND;
            else if (op_ff == OP_CREATE) begin
               if (entry_valid_ff[id_idx])     res_status_in = ST_DUPLICATE;
               else                            res_status_in = ST_NO_ROOM;
            end
            else if (entry_valid_ff[id_idx])   res_status_in = ST_OK;
            else                               res_status_in = ST_NOT_FOUND;
         end
         S_LOAD: begin
            mark_addr_in           = entry_rd_data[EW-1:CW];
            mark_left_in           = entry_rd_data[CW-1:0];
            mark_val_in            = 1'b0;
            res_start_in           = entry_rd_data[EW-1:CW];
            res_count_in           = entry_rd_data[CW-1:0];
            entry_valid_in[id_idx] = 1'b0;
         end
         S_SCAN: begin
            pend_in     = addr_ff < (ABW + 1)'(NUM_BLOCKS);
            pend_idx_in = addr_ff[ABW-1:0];
            addr_in     = addr_ff + (ABW + 1)'(1);
            if (pend_ff) begin
               if (map_rd_data) begin
                  run_in       = '0;
                  run_units_in = '0;
               end else begin
                  run_in       = run_next;
                  run_units_in = units_next;
                  run_start_in = start_next;
               end
            end
            if (fit) begin
               mark_addr_in           = start_next;
               mark_left_in           = run_next;
               mark_val_in            = 1'b1;
               res_status_in          = ST_OK;
               res_start_in           = start_next;
               res_count_in           = run_next;
               entry_valid_in[id_idx] = 1'b1;
            end
         end
         S_MARK: begin
            mark_addr_in = mark_addr_ff + ABW'(1);
            mark_left_in = mark_left_ff - CW'(1);
         end
         S_RESULT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_start_in  = start_wide[START_W-1:0];
               rsp_count_in  = count_wide[COUNT_W-1:0];
            end
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         mark_addr_ff   <= '0;
         entry_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         mark_addr_ff   <= mark_addr_in;
         entry_valid_ff <= entry_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      units_ff      <= units_in;
      addr_ff       <= addr_in;
      pend_ff       <= pend_in;
      pend_idx_ff   <= pend_idx_in;
      run_ff        <= run_in;
      run_units_ff  <= run_units_in;
      run_start_ff  <= run_start_in;
      mark_left_ff  <= mark_left_in;
      mark_val_ff   <= mark_val_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      res_count_ff  <= res_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_start_block = rsp_start_ff;
   assign rsp_block_count = rsp_count_ff;

   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_RESULT)
      else $error("response posted outside the result step");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_start_ff == '0 && rsp_count_ff == '0))
      else $error("error response carries a nonzero run");

   a_mark_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MARK |-> mark_left_ff != '0)
      else $error("mark pass with no blocks left");

   a_fit_marks_used: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && fit) |=> (state_ff == S_MARK && mark_val_ff))
      else $error("found run not marked as used");

   a_load_is_delete: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LOAD |-> op_ff == OP_DELETE)
      else $error("table load outside a delete");

endmodule
